FILE: hdl/kalman_scalar_obs_update_top_macros.svh
// assertion macros for the scalar observation update block
`ifndef KALMAN_SCALAR_OBS_UPDATE_TOP_MACROS_SVH
`define KALMAN_SCALAR_OBS_UPDATE_TOP_MACROS_SVH
`define KSOU_ASSERT(label, en, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (en) |-> (prop)) else $error(msg);
`define KSOU_ASSERT_NEXT(label, en, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (en) |=> (prop)) else $error(msg);
`endif

FILE: hdl/ksou_pkg.sv
// ---------------------------------------------------------------------------
// ksou_pkg
// types, constants and arithmetic helpers of the observation update
// ---------------------------------------------------------------------------
`default_nettype none
package ksou_pkg;
  localparam int WORD_BITS_DEF = 32;
  localparam int FRACTION_BITS_DEF = 16;
  localparam logic [30:0] OBS_NOISE_RST = 31'd655;
  localparam int FIFO_DEPTH = 4;

  typedef struct packed {
    logic signed [31:0] est_pos;
    logic signed [31:0] est_vel;
    logic signed [31:0] est_base_vel;
    logic [30:0]        cov_00;
    logic signed [31:0] cov_01;
    logic signed [31:0] cov_02;
    logic [30:0]        cov_11;
    logic signed [31:0] cov_12;
    logic [30:0]        cov_22;
    logic signed [31:0] observation;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] new_pos;
    logic signed [31:0] new_vel;
    logic [30:0]        new_base_vel;
    logic [30:0]        new_cov_00;
    logic signed [31:0] new_cov_01;
    logic signed [31:0] new_cov_02;
    logic signed [31:0] new_cov_11;
    logic signed [31:0] new_cov_12;
    logic signed [31:0] new_cov_22;
  } out_item_t;

  // front-end classification: s is zero, gains all zero
  typedef struct packed {
    in_item_t           item;
    logic               s_zero;
    logic [31:0]        s;
    logic signed [31:0] innov;
  } job_t;

  function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic signed [63:0] rnd(input logic signed [63:0] p,
                                             input int fb);
    logic [63:0] m;
    m = p[63] ? 64'(-p) : 64'(p);
    m = (m + (64'd1 << (fb - 1))) >> fb;
    return p[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [30:0] clamp31(input logic signed [63:0] v);
    if (v < 0) return '0;
    if (v > 64'sd2147483647) return 31'h7fffffff;
    return v[30:0];
  endfunction
endpackage
`default_nettype wire

FILE: hdl/ksou_if.sv
// ---------------------------------------------------------------------------
// ksou_if
// valid/ready channel carrying one payload
// ---------------------------------------------------------------------------
`default_nettype none
interface ksou_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/ksou_front.sv
// ---------------------------------------------------------------------------
// ksou_front
// accepts items, forms s and the innovation, queues jobs for the back end
// ---------------------------------------------------------------------------
`default_nettype none
module ksou_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [30:0]      obs_noise,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire ksou_pkg::in_item_t in_data,
  output logic                  job_valid,
  input  wire logic             job_ready,
  output ksou_pkg::job_t        job_data
);
  import ksou_pkg::*;
  localparam int AW = $clog2(FIFO_DEPTH);
  job_t            mem [FIFO_DEPTH];
  logic [AW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]     cnt_r, cnt_nxt;
  job_t            job_w;
  logic            push, pop;
  logic signed [63:0] e;

  always_comb begin
    job_w.item = in_data;
    job_w.s = {1'b0, in_data.cov_00} + {1'b0, obs_noise};
    job_w.s_zero = (job_w.s == '0);
    e = sat32(64'(in_data.observation) - 64'(in_data.est_pos));
    job_w.innov = e[31:0];
  end

  assign in_ready = (cnt_r != (AW+1)'(FIFO_DEPTH));
  assign job_valid = (cnt_r != '0);
  assign job_data = mem[rp_r];
  assign push = in_valid && in_ready;
  assign pop = job_valid && job_ready;
  assign wp_nxt = push ? wp_r + 1'b1 : wp_r;
  assign rp_nxt = pop ? rp_r + 1'b1 : rp_r;
  assign cnt_nxt = cnt_r + (AW+1)'(push) - (AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= job_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
  end
endmodule
`default_nettype wire

FILE: hdl/ksou_back.sv
// ---------------------------------------------------------------------------
// ksou_back
// pipelined gain division and state and covariance correction
// ---------------------------------------------------------------------------
`default_nettype none
`include "kalman_scalar_obs_update_top_macros.svh"
module ksou_back #(
  parameter int FRACTION_BITS = ksou_pkg::FRACTION_BITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            job_valid,
  output logic                 job_ready,
  input  wire ksou_pkg::job_t  job_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output ksou_pkg::out_item_t  out_data
);
  import ksou_pkg::*;
  // restoring divider: one quotient bit per stage
  localparam int QB = 32 + FRACTION_BITS;
  localparam int NS = QB + 3;

  typedef struct packed {
    job_t        j;
    logic [63:0] r0, r1, r2;
    logic [63:0] q0, q1, q2;
    logic        n1, n2;
  } dv_t;

  dv_t         dv_r [QB+1];
  logic [QB:0] v_r;
  logic        adv;

  typedef struct packed {
    job_t               j;
    logic signed [31:0] k0, k1, k2;
  } kg_t;
  kg_t kg_r;
  logic kv_r;

  typedef struct packed {
    job_t               j;
    logic signed [63:0] m0, m1, m2, m3, m4, m5, m6, m7, m8;
  } pr_t;
  pr_t pr_r;
  logic pv_r;

  out_item_t res_r;
  logic      ov_r;

  // whole pipe advances together; stalls only when the output is held
  assign adv = !ov_r || out_ready;
  assign job_ready = adv;
  assign out_valid = ov_r;
  assign out_data = res_r;

  function automatic logic signed [31:0] gfin(input logic [63:0] q, input logic n);
    logic signed [63:0] sq;
    sq = n ? -$signed(q) : $signed(q);
    sq = sat32(sq);
    return sq[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_r[0].j  <= job_data;
      dv_r[0].r0 <= '0; dv_r[0].r1 <= '0; dv_r[0].r2 <= '0;
      dv_r[0].q0 <= 64'({job_data.item.cov_00, FRACTION_BITS'(0)});
      dv_r[0].q1 <= 64'((job_data.item.cov_01[31] ? -64'(job_data.item.cov_01)
                                  : 64'(job_data.item.cov_01)) << FRACTION_BITS);
      dv_r[0].q2 <= 64'((job_data.item.cov_02[31] ? -64'(job_data.item.cov_02)
                                  : 64'(job_data.item.cov_02)) << FRACTION_BITS);
      dv_r[0].n1 <= job_data.item.cov_01[31];
      dv_r[0].n2 <= job_data.item.cov_02[31];
      for (int i = 0; i < QB; i++) begin
        logic [63:0] t0, t1, t2, q0, q1, q2, d;
        d = 64'(dv_r[i].j.s);
        t0 = {dv_r[i].r0[62:0], dv_r[i].q0[QB-1]};
        t1 = {dv_r[i].r1[62:0], dv_r[i].q1[QB-1]};
        t2 = {dv_r[i].r2[62:0], dv_r[i].q2[QB-1]};
        q0 = {dv_r[i].q0[62:0], 1'b0};
        q1 = {dv_r[i].q1[62:0], 1'b0};
        q2 = {dv_r[i].q2[62:0], 1'b0};
        if (t0 >= d) begin t0 = t0 - d; q0[0] = 1'b1; end
        if (t1 >= d) begin t1 = t1 - d; q1[0] = 1'b1; end
        if (t2 >= d) begin t2 = t2 - d; q2[0] = 1'b1; end
        dv_r[i+1].j <= dv_r[i].j;
        dv_r[i+1].r0 <= t0; dv_r[i+1].r1 <= t1; dv_r[i+1].r2 <= t2;
        dv_r[i+1].q0 <= q0; dv_r[i+1].q1 <= q1; dv_r[i+1].q2 <= q2;
        dv_r[i+1].n1 <= dv_r[i].n1; dv_r[i+1].n2 <= dv_r[i].n2;
      end
      kg_r.j <= dv_r[QB].j;
      if (dv_r[QB].j.s_zero) begin
        kg_r.k0 <= '0; kg_r.k1 <= '0; kg_r.k2 <= '0;
      end else begin
        kg_r.k0 <= gfin(64'(dv_r[QB].q0[QB-1:0]), 1'b0);
        kg_r.k1 <= gfin(64'(dv_r[QB].q1[QB-1:0]), dv_r[QB].n1);
        kg_r.k2 <= gfin(64'(dv_r[QB].q2[QB-1:0]), dv_r[QB].n2);
      end
      pr_r.j  <= kg_r.j;
      pr_r.m0 <= rnd(64'(kg_r.k0) * 64'(kg_r.j.innov), FRACTION_BITS);
      pr_r.m1 <= rnd(64'(kg_r.k1) * 64'(kg_r.j.innov), FRACTION_BITS);
      pr_r.m2 <= rnd(64'(kg_r.k2) * 64'(kg_r.j.innov), FRACTION_BITS);
      pr_r.m3 <= rnd(64'(kg_r.k0) * $signed({33'd0, kg_r.j.item.cov_00}), FRACTION_BITS);
      pr_r.m4 <= rnd(64'(kg_r.k0) * 64'(kg_r.j.item.cov_01), FRACTION_BITS);
      pr_r.m5 <= rnd(64'(kg_r.k0) * 64'(kg_r.j.item.cov_02), FRACTION_BITS);
      pr_r.m6 <= rnd(64'(kg_r.k1) * 64'(kg_r.j.item.cov_01), FRACTION_BITS);
      pr_r.m7 <= rnd(64'(kg_r.k1) * 64'(kg_r.j.item.cov_02), FRACTION_BITS);
      pr_r.m8 <= rnd(64'(kg_r.k2) * 64'(kg_r.j.item.cov_02), FRACTION_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      logic signed [63:0] a, n2;
      a = sat32(64'(pr_r.j.item.est_pos) + pr_r.m0);  res_r.new_pos <= a[31:0];
      a = sat32(64'(pr_r.j.item.est_vel) + pr_r.m1);  res_r.new_vel <= a[31:0];
      n2 = 64'(pr_r.j.item.est_base_vel) + pr_r.m2;
      if (n2 < 0) n2 = -n2;
      res_r.new_base_vel <= clamp31(n2);
      res_r.new_cov_00 <= clamp31($signed({33'd0, pr_r.j.item.cov_00}) - pr_r.m3);
      a = sat32(64'(pr_r.j.item.cov_01) - pr_r.m4); res_r.new_cov_01 <= a[31:0];
      a = sat32(64'(pr_r.j.item.cov_02) - pr_r.m5); res_r.new_cov_02 <= a[31:0];
      a = sat32($signed({33'd0, pr_r.j.item.cov_11}) - pr_r.m6); res_r.new_cov_11 <= a[31:0];
      a = sat32(64'(pr_r.j.item.cov_12) - pr_r.m7); res_r.new_cov_12 <= a[31:0];
      a = sat32($signed({33'd0, pr_r.j.item.cov_22}) - pr_r.m8); res_r.new_cov_22 <= a[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0; kv_r <= 1'b0; pv_r <= 1'b0; ov_r <= 1'b0;
    end else if (adv) begin
      v_r <= {v_r[QB-1:0], job_valid};
      kv_r <= v_r[QB];
      pv_r <= kv_r;
      ov_r <= pv_r;
    end
  end

  `KSOU_ASSERT_NEXT(a_hold, ov_r && !out_ready, ov_r && $stable(res_r), "result dropped while stalled")
  `KSOU_ASSERT(a_rdy, ov_r && !out_ready, !job_ready, "job taken while output held")
  `KSOU_ASSERT_NEXT(a_flow, adv && pv_r, ov_r, "item lost in final stage")
  `KSOU_ASSERT(a_depth, 1'b1, $countones({v_r, kv_r, pv_r, ov_r}) <= NS + 1, "pipe count wrong")
endmodule
`default_nettype wire

FILE: hdl/kalman_scalar_obs_update_top.sv
// ---------------------------------------------------------------------------
// kalman_scalar_obs_update_top
// scalar observation Kalman measurement update, Q16.16 fixed point
// ---------------------------------------------------------------------------
// One item per cycle sustained while the output is not held. After its item is
// accepted, a result passes through the front queue, 33 + FRACTION_BITS divider
// registers (the first loads, the other 32 + FRACTION_BITS each resolve one
// quotient bit of the three gains), one stage that saturates the gains and one
// that rounds the products, after which the result sits in the output register.
// A held output stalls the whole back pipe; the four-entry queue between front
// and back keeps taking items until it is full.
`default_nettype none
module kalman_scalar_obs_update_top #(
  parameter int FRACTION_BITS = ksou_pkg::FRACTION_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  ksou_if.sink     in_ch,
  ksou_if.source   out_ch,
  ksou_if.sink     cfg_ch
);
  import ksou_pkg::*;
  logic [30:0] obs_noise_r;
  logic        job_valid, job_ready;
  job_t        job_data;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) obs_noise_r <= OBS_NOISE_RST;
    else if (cfg_ch.valid) obs_noise_r <= cfg_ch.data;
  end

  ksou_front u_front (
    .clk, .rst_n, .obs_noise(obs_noise_r),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .job_valid, .job_ready, .job_data
  );

  ksou_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk, .rst_n, .job_valid, .job_ready, .job_data,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
  );
endmodule
`default_nettype wire
